/* rtl/core/gmd_pkg.sv */
// Shared types and constants of the gravity motion derivative block.
package gmd_pkg;

    // c in mm/ns as a Q16.16 code
    localparam logic [63:0] LIGHT_SPEED_Q16 = 64'd19647199;
    localparam logic [47:0] NEUTRON_MASS_Q32 = 48'd4035400947466;

    localparam logic [1:0] STAT_COMPUTED = 2'd0;
    localparam logic [1:0] STAT_SKIPPED  = 2'd1;
    localparam logic [1:0] STAT_ZERO_MOM = 2'd2;

    localparam logic [1:0] CFG_CHARGE = 2'd0;
    localparam logic [1:0] CFG_MASS   = 2'd1;

    typedef struct packed {
        logic signed [47:0] mom_x;
        logic signed [47:0] mom_y;
        logic signed [47:0] mom_z;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic [1:0]         status;
    } gmd_item_t;

    typedef enum logic [1:0] {
        AR_MUL,
        AR_DIV,
        AR_SQRT,
        AR_CDIV
    } ar_op_t;

    typedef struct packed {
        ar_op_t       op;
        logic [127:0] a;
        logic [63:0]  b;
    } ar_req_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_P2,
        BK_SQP,
        BK_DIR,
        BK_MM,
        BK_SQE,
        BK_XM,
        BK_XD,
        BK_FM,
        BK_FD,
        BK_T1,
        BK_T2,
        BK_OUT
    } bk_state_t;

endpackage

/* rtl/core/gmd_front.sv */
// Front end: takes input items, classifies them and queues them for the back end.
module gmd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [239:0]      s_tdata,
    input  logic [4:0]        charge,
    input  logic [47:0]       mass,
    output logic              q_valid,
    input  logic              q_ready,
    output gmd_pkg::gmd_item_t q_item
);

    gmd_pkg::gmd_item_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    gmd_pkg::gmd_item_t in_item;
    logic push, pop;

    always_comb begin
        in_item.mom_x   = s_tdata[47:0];
        in_item.mom_y   = s_tdata[95:48];
        in_item.mom_z   = s_tdata[143:96];
        in_item.field_x = s_tdata[175:144];
        in_item.field_y = s_tdata[207:176];
        in_item.field_z = s_tdata[239:208];
        if (charge != 5'd0 || mass == 48'd0) begin
            in_item.status = gmd_pkg::STAT_SKIPPED;
        end else if (s_tdata[143:0] == 144'd0) begin
            in_item.status = gmd_pkg::STAT_ZERO_MOM;
        end else begin
            in_item.status = gmd_pkg::STAT_COMPUTED;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/core/gmd_arith.sv */
// Shared iterative unit: shift-add multiply, restoring divide, square root, divide by c.
module gmd_arith (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  gmd_pkg::ar_req_t  req,
    output logic              busy,
    output logic              done,
    output logic [127:0]      result
);

    gmd_pkg::ar_op_t op_reg;
    logic         busy_reg, done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] acc_reg, a_reg;
    logic [63:0]  b_reg;
    logic [65:0]  rem_reg;

    logic [64:0]  div_sh;
    logic [65:0]  sq_sh, sq_trial;
    logic [28:0]  cd_sh, cd_rem;
    logic [3:0]   cd_dig;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

    assign div_sh   = {rem_reg[63:0], a_reg[127]};
    assign sq_sh    = {rem_reg[63:0], a_reg[127:126]};
    assign sq_trial = {acc_reg[63:0], 2'b01};
    assign cd_sh    = {rem_reg[24:0], a_reg[127:124]};

    // radix-16 digit against the constant multiples of c
    always_comb begin
        cd_dig = 4'd0;
        cd_rem = cd_sh;
        for (int k = 1; k < 16; k++) begin
            if (cd_sh >= 29'(gmd_pkg::LIGHT_SPEED_Q16 * 64'(k))) begin
                cd_dig = 4'(k);
                cd_rem = cd_sh - 29'(gmd_pkg::LIGHT_SPEED_Q16 * 64'(k));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            op_reg  <= req.op;
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= 128'd0;
            rem_reg <= 66'd0;
            case (req.op)
                gmd_pkg::AR_DIV:  cnt_reg <= 7'd127;
                gmd_pkg::AR_CDIV: cnt_reg <= 7'd31;
                default:          cnt_reg <= 7'd63;
            endcase
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 7'd1;
            case (op_reg)
                gmd_pkg::AR_MUL: begin
                    if (b_reg[0]) begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= {a_reg[126:0], 1'b0};
                    b_reg <= {1'b0, b_reg[63:1]};
                end
                gmd_pkg::AR_DIV: begin
                    if (div_sh >= {1'b0, b_reg}) begin
                        rem_reg <= {1'b0, div_sh - {1'b0, b_reg}};
                        acc_reg <= {acc_reg[126:0], 1'b1};
                    end else begin
                        rem_reg <= {1'b0, div_sh};
                        acc_reg <= {acc_reg[126:0], 1'b0};
                    end
                    a_reg <= {a_reg[126:0], 1'b0};
                end
                gmd_pkg::AR_SQRT: begin
                    if (sq_sh >= sq_trial) begin
                        rem_reg <= sq_sh - sq_trial;
                        acc_reg <= {acc_reg[126:0], 1'b1};
                    end else begin
                        rem_reg <= sq_sh;
                        acc_reg <= {acc_reg[126:0], 1'b0};
                    end
                    a_reg <= {a_reg[125:0], 2'b00};
                end
                gmd_pkg::AR_CDIV: begin
                    rem_reg <= {37'd0, cd_rem};
                    acc_reg <= {acc_reg[123:0], cd_dig};
                    a_reg   <= {a_reg[123:0], 4'd0};
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

endmodule

/* rtl/core/gmd_back.sv */
// Back end: sequences the arithmetic for one item and holds the result register.
module gmd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [47:0]        mass,
    input  logic               q_valid,
    output logic               q_ready,
    input  gmd_pkg::gmd_item_t q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [351:0]       m_tdata,
    output logic [1:0]         m_tuser
);

    gmd_pkg::bk_state_t state_reg, state_next;
    gmd_pkg::gmd_item_t item_reg;
    logic [1:0]   idx_reg;
    logic         pend_reg;
    logic [127:0] p2_reg, x_reg, tmp_reg;
    logic [63:0]  mag_reg, energy_reg, inv_reg;
    logic [31:0]  dir_reg [3];
    logic [63:0]  force_reg [3];
    logic         m_valid_reg;
    logic [351:0] m_data_reg;
    logic [1:0]   m_user_reg;

    logic         ar_start, ar_busy, ar_done;
    logic [127:0] ar_result;
    gmd_pkg::ar_req_t ar_req;

    logic [47:0]  pm [3];
    logic         pneg [3];
    logic [31:0]  gm [3];
    logic         gneg [3];
    logic         x_sat, skip_f, compute_st, out_load;
    logic [63:0]  f_mag;
    logic [31:0]  d_lo;

    always_comb begin
        pneg[0] = item_reg.mom_x[47];
        pneg[1] = item_reg.mom_y[47];
        pneg[2] = item_reg.mom_z[47];
        pm[0] = pneg[0] ? -item_reg.mom_x : item_reg.mom_x;
        pm[1] = pneg[1] ? -item_reg.mom_y : item_reg.mom_y;
        pm[2] = pneg[2] ? -item_reg.mom_z : item_reg.mom_z;
        gneg[0] = item_reg.field_x[31];
        gneg[1] = item_reg.field_y[31];
        gneg[2] = item_reg.field_z[31];
        gm[0] = gneg[0] ? -item_reg.field_x : item_reg.field_x;
        gm[1] = gneg[1] ? -item_reg.field_y : item_reg.field_y;
        gm[2] = gneg[2] ? -item_reg.field_z : item_reg.field_z;
    end

    assign x_sat  = (x_reg[127:96] != 32'd0);
    assign skip_f = (state_reg == gmd_pkg::BK_FM) && (x_sat || gm[idx_reg] == 32'd0);
    assign out_load = (state_reg == gmd_pkg::BK_OUT) && (!m_valid_reg || m_tready);

    gmd_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ar_start),
        .req     (ar_req),
        .busy    (ar_busy),
        .done    (ar_done),
        .result  (ar_result)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gmd_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = (q_item.status == gmd_pkg::STAT_COMPUTED) ?
                                 gmd_pkg::BK_P2 : gmd_pkg::BK_OUT;
                end
            end
            gmd_pkg::BK_P2:  if (ar_done && idx_reg == 2'd2) state_next = gmd_pkg::BK_SQP;
            gmd_pkg::BK_SQP: if (ar_done) state_next = gmd_pkg::BK_DIR;
            gmd_pkg::BK_DIR: if (ar_done && idx_reg == 2'd2) state_next = gmd_pkg::BK_MM;
            gmd_pkg::BK_MM:  if (ar_done) state_next = gmd_pkg::BK_SQE;
            gmd_pkg::BK_SQE: if (ar_done) state_next = gmd_pkg::BK_XM;
            gmd_pkg::BK_XM:  if (ar_done) state_next = gmd_pkg::BK_XD;
            gmd_pkg::BK_XD:  if (ar_done) state_next = gmd_pkg::BK_FM;
            gmd_pkg::BK_FM: begin
                if (skip_f) begin
                    state_next = (idx_reg == 2'd2) ? gmd_pkg::BK_T1 : gmd_pkg::BK_FM;
                end else if (ar_done) begin
                    state_next = gmd_pkg::BK_FD;
                end
            end
            gmd_pkg::BK_FD: begin
                if (ar_done) begin
                    state_next = (idx_reg == 2'd2) ? gmd_pkg::BK_T1 : gmd_pkg::BK_FM;
                end
            end
            gmd_pkg::BK_T1:  if (ar_done) state_next = gmd_pkg::BK_T2;
            gmd_pkg::BK_T2:  if (ar_done) state_next = gmd_pkg::BK_OUT;
            gmd_pkg::BK_OUT: if (out_load) state_next = gmd_pkg::BK_IDLE;
            default:         state_next = gmd_pkg::BK_IDLE;
        endcase
    end

    // outputs: queue pop and arithmetic requests
    always_comb begin
        q_ready    = (state_reg == gmd_pkg::BK_IDLE);
        compute_st = 1'b1;
        ar_req.op  = gmd_pkg::AR_MUL;
        ar_req.a   = 128'd0;
        ar_req.b   = 64'd0;
        case (state_reg)
            gmd_pkg::BK_P2: begin
                ar_req.a = {80'd0, pm[idx_reg]};
                ar_req.b = {16'd0, pm[idx_reg]};
            end
            gmd_pkg::BK_SQP: begin
                ar_req.op = gmd_pkg::AR_SQRT;
                ar_req.a  = p2_reg;
            end
            gmd_pkg::BK_DIR: begin
                ar_req.op = gmd_pkg::AR_DIV;
                ar_req.a  = {50'd0, pm[idx_reg], 30'd0};
                ar_req.b  = mag_reg;
            end
            gmd_pkg::BK_MM: begin
                ar_req.a = {80'd0, mass};
                ar_req.b = {16'd0, mass};
            end
            gmd_pkg::BK_SQE: begin
                ar_req.op = gmd_pkg::AR_SQRT;
                ar_req.a  = p2_reg;
            end
            gmd_pkg::BK_XM: begin
                ar_req.a = {80'd0, mass};
                ar_req.b = energy_reg;
            end
            gmd_pkg::BK_XD: begin
                ar_req.op = gmd_pkg::AR_DIV;
                ar_req.a  = tmp_reg;
                ar_req.b  = mag_reg;
            end
            gmd_pkg::BK_FM: begin
                ar_req.a = x_reg;
                ar_req.b = {32'd0, gm[idx_reg]};
            end
            gmd_pkg::BK_FD, gmd_pkg::BK_T2: begin
                ar_req.op = gmd_pkg::AR_CDIV;
                ar_req.a  = tmp_reg;
            end
            gmd_pkg::BK_T1: begin
                ar_req.op = gmd_pkg::AR_DIV;
                ar_req.a  = {16'd0, energy_reg, 48'd0};
                ar_req.b  = mag_reg;
            end
            default: compute_st = 1'b0;
        endcase
        ar_start = compute_st && !pend_reg && !ar_busy && !skip_f;
    end

    // force magnitude clamp, sign follows the negated field
    always_comb begin
        if (!gneg[idx_reg]) begin
            f_mag = (ar_result[127:64] != 64'd0 || ar_result[63:0] > 64'h8000_0000_0000_0000) ?
                    64'h8000_0000_0000_0000 : ar_result[63:0];
        end else begin
            f_mag = (ar_result[127:64] != 64'd0 || ar_result[63] != 1'b0) ?
                    64'h7FFF_FFFF_FFFF_FFFF : ar_result[63:0];
        end
        d_lo = ar_result[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gmd_pkg::BK_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ar_start) begin
                pend_reg <= 1'b1;
            end else if (ar_done) begin
                pend_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            gmd_pkg::BK_IDLE: begin
                item_reg <= q_item;
                idx_reg  <= 2'd0;
                p2_reg   <= 128'd0;
                inv_reg  <= 64'd0;
                for (int k = 0; k < 3; k++) begin
                    dir_reg[k]   <= 32'd0;
                    force_reg[k] <= 64'd0;
                end
            end
            gmd_pkg::BK_P2: begin
                if (ar_done) begin
                    p2_reg  <= p2_reg + ar_result;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
            end
            gmd_pkg::BK_SQP: if (ar_done) mag_reg <= ar_result[63:0];
            gmd_pkg::BK_DIR: begin
                if (ar_done) begin
                    dir_reg[idx_reg] <= pneg[idx_reg] ? -d_lo : d_lo;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
            end
            // p2 plus mass squared moved up to Q.80
            gmd_pkg::BK_MM: if (ar_done) p2_reg <= p2_reg + {ar_result[111:0], 16'd0};
            gmd_pkg::BK_SQE: if (ar_done) energy_reg <= ar_result[63:0];
            gmd_pkg::BK_XM: if (ar_done) tmp_reg <= ar_result;
            gmd_pkg::BK_XD: if (ar_done) x_reg <= ar_result;
            gmd_pkg::BK_FM: begin
                if (skip_f) begin
                    if (gm[idx_reg] != 32'd0) begin
                        force_reg[idx_reg] <= gneg[idx_reg] ? 64'h7FFF_FFFF_FFFF_FFFF :
                                              64'h8000_0000_0000_0000;
                    end
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end else if (ar_done) begin
                    tmp_reg <= ar_result;
                end
            end
            gmd_pkg::BK_FD: begin
                if (ar_done) begin
                    force_reg[idx_reg] <= gneg[idx_reg] ? f_mag : -f_mag;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
            end
            gmd_pkg::BK_T1: if (ar_done) tmp_reg <= ar_result;
            gmd_pkg::BK_T2: begin
                if (ar_done) begin
                    inv_reg <= (ar_result[127:64] != 64'd0) ? {64{1'b1}} : ar_result[63:0];
                end
            end
            default: idx_reg <= idx_reg;
        endcase
        if (out_load) begin
            m_data_reg <= {inv_reg, force_reg[2], force_reg[1], force_reg[0],
                           dir_reg[2], dir_reg[1], dir_reg[0]};
            m_user_reg <= item_reg.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* rtl/core/gravity_motion_derivative.sv */
// Top level of the gravity motion derivative block.
//
// Input channel s_*: one item per handshake carrying momentum (Q8.40) and
// field (Q16.16) vectors. Output channel m_*: one result item per input item,
// in order: unit direction, force per axis, inverse velocity, and status in
// m_tuser (computed, skipped, zero momentum).
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write charge (0) and mass (1);
// write only while no item is in flight.
// A computed item is worked by the single shared iterative unit in the back end
// (8 multiplies, 2 square roots, 5 divides and 4 divides by c, one after another);
// skipped and zero-momentum items skip the arithmetic and go from the queue to
// the output register. The back end works on one item at a time.
// A two-item queue in front accepts items while the back end works, and the
// output register lets the back end finish an item while the receiver stalls;
// when the result waits, the back end holds and the queue fills.
// Reset empties the queue and the output register, sets charge to zero and
// mass to the neutron mass.
module gravity_motion_derivative (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mom_x, mom_y, mom_z, field_x, field_y, field_z
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dir_x, dir_y, dir_z, force_x, force_y, force_z, inv_vel
    output logic [351:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);

    logic [4:0]  charge_reg;
    logic [47:0] mass_reg;
    logic        q_valid, q_ready;
    gmd_pkg::gmd_item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_reg <= 5'd0;
            mass_reg   <= gmd_pkg::NEUTRON_MASS_Q32;
        end else if (cfg_wr_en) begin
            if (cfg_addr == gmd_pkg::CFG_CHARGE) begin
                charge_reg <= cfg_wdata[4:0];
            end else if (cfg_addr == gmd_pkg::CFG_MASS) begin
                mass_reg <= cfg_wdata;
            end
        end
    end

    gmd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .charge   (charge_reg),
        .mass     (mass_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    gmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mass     (mass_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
